>>> src/tws_pkg.sv
package tws_pkg;

  // Sizing defaults
  localparam int TABLE_SLOTS_DEF = 16;

  // Field widths
  localparam int REQ_W  = 3;
  localparam int ID_W   = 16;
  localparam int MIN_W  = 11;
  localparam int MASK_W = 7;
  localparam int ACT_W  = 16;
  localparam int DAY_W  = 16;
  localparam int ST_W   = 3;
  localparam int WD_W   = 3;

  // Minutes in a full day (24:00)
  localparam logic [MIN_W-1:0] FULL_DAY = 11'd1440;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SKIP   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ACTIVE = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP       = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_ZERO_ID   = 3'd4;

  // Request beat
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   entry_id;
    logic [MIN_W-1:0]  start_minute;
    logic [MIN_W-1:0]  end_minute;
    logic [MASK_W-1:0] weekday_mask;
    logic [ACT_W-1:0]  activity_code;
    logic [MIN_W-1:0]  time_of_day;
    logic [DAY_W-1:0]  world_day;
    logic              active_flag;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             entry_changed;
    logic             active_changed;
    logic [ID_W-1:0]  current_entry;
    logic [ID_W-1:0]  previous_entry;
    logic [ACT_W-1:0] current_activity;
    logic             schedule_enabled;
  } out_item_t;

  // One table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [MIN_W-1:0]  start_m;
    logic [MIN_W-1:0]  end_m;
    logic [MASK_W-1:0] mask;
    logic [ACT_W-1:0]  act;
  } entry_t;

  // Search key fed to the compare unit
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [MIN_W-1:0] tod;
    logic [WD_W-1:0]  wd;
    logic             has_wd;
  } match_key_t;

  // Compare unit flags
  typedef struct packed {
    logic id_hit;
    logic win_hit;
  } match_res_t;

endpackage

>>> src/time_window_schedule_matcher.sv
// Time-window schedule matcher.
// Request channel: drive in_data and raise start; the beat is taken at the
// rising edge where start is high and busy is low. Requests are tick, add,
// remove, skip and set active.
// Result channel: one result beat per request, shown on out_data for exactly
// one cycle while out_valid is high. The receiver cannot stall it and must
// take it in that cycle.
// Search: tick, add, skip and remove search the table one entry per cycle
// through a single compare unit, with the table read through its registered
// port. The search ends early when it hits. Requests with id zero, set
// active, tick while disabled and unused codes do not search the table. A
// remove that hits then moves each later entry down one slot before its
// result. busy is low in the strobe cycle, so the next request can be taken
// there.
// Reset: table empty, no current entry, schedule enabled, no strobe.
module time_window_schedule_matcher #(
  parameter int TABLE_SLOTS = tws_pkg::TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tws_pkg::in_item_t   in_data,
  output logic                busy,
  output logic                out_valid,
  output tws_pkg::out_item_t  out_data
);
  import tws_pkg::*;

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  // (day - 1) mod 7: octal digits summed, since 8 is 1 mod 7
  function automatic logic [WD_W-1:0] week_day(input logic [DAY_W-1:0] d);
    logic [DAY_W-1:0] dm;
    logic [5:0]       s;
    logic [3:0]       t;
    logic [3:0]       r;
    dm = d - 1'b1;
    s  = {3'b0, dm[2:0]} + {3'b0, dm[5:3]} + {3'b0, dm[8:6]}
       + {3'b0, dm[11:9]} + {3'b0, dm[14:12]} + {5'b0, dm[15]};
    t  = {1'b0, s[5:3]} + {1'b0, s[2:0]};
    r  = (t >= 4'd7) ? (t - 4'd7) : t;
    return r[WD_W-1:0];
  endfunction

  state_t            state_r, state_nxt;
  in_item_t          req_r, req_nxt;
  logic [WD_W-1:0]   wd_r, wd_nxt;
  logic              has_wd_r, has_wd_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [ID_W-1:0]   now_r, now_nxt;
  logic [ID_W-1:0]   prior_r, prior_nxt;
  logic [ACT_W-1:0]  cur_act_r, cur_act_nxt;
  logic              enabled_r, enabled_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic              ent_chg_r, ent_chg_nxt;
  logic              act_chg_r, act_chg_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;
  match_key_t        key;
  match_res_t        res;

  logic              needs_scan;
  logic              hit;
  logic              done;
  logic [ID_W-1:0]   found_id;
  logic [ACT_W-1:0]  found_act;

  // Entry storage
  tws_table #(
    .SLOTS (TABLE_SLOTS),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_r[IW-1:0]),
    .rd_data (rd_data)
  );

  // Shared compare unit
  assign key = '{id: req_r.entry_id, tod: req_r.time_of_day, wd: wd_r, has_wd: has_wd_r};

  tws_match u_match (
    .ent (rd_data),
    .key (key),
    .res (res)
  );

  // Search control
  always_comb begin
    case (req_r.req_type)
      REQ_TICK:                     needs_scan = enabled_r;
      REQ_ADD, REQ_REMOVE, REQ_SKIP: needs_scan = (req_r.entry_id != '0);
      default:                      needs_scan = 1'b0;
    endcase
    hit  = pend_r && ((req_r.req_type == REQ_TICK) ? res.win_hit : res.id_hit);
    done = !needs_scan || hit || (idx_r >= count_r);
    found_id  = hit ? rd_data.id : '0;
    found_act = hit ? rd_data.act : '0;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    wd_nxt        = wd_r;
    has_wd_nxt    = has_wd_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    now_nxt       = now_r;
    prior_nxt     = prior_r;
    cur_act_nxt   = cur_act_r;
    enabled_nxt   = enabled_r;
    status_nxt    = status_r;
    ent_chg_nxt   = ent_chg_r;
    act_chg_nxt   = act_chg_r;
    out_valid_nxt = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = count_r[IW-1:0];
    wr_data       = rd_data;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_data;
          wd_nxt     = week_day(in_data.world_day);
          has_wd_nxt = (in_data.world_day != '0);
          idx_nxt    = '0;
          pend_nxt   = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (!done) begin
          // issue the next table read
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          ent_chg_nxt   = 1'b0;
          act_chg_nxt   = 1'b0;
          pend_nxt      = 1'b0;
          case (req_r.req_type)
            REQ_TICK: begin
              if (enabled_r) begin
                if (found_id != now_r) begin
                  prior_nxt   = now_r;
                  now_nxt     = found_id;
                  ent_chg_nxt = 1'b1;
                end
                cur_act_nxt = found_act;
              end
            end
            REQ_ADD: begin
              if (req_r.entry_id == '0) begin
                status_nxt = ST_ZERO_ID;
              end else if (hit) begin
                status_nxt = ST_DUP;
              end else if (count_r >= SLOTS_C) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en         = 1'b1;
                wr_data.id    = req_r.entry_id;
                wr_data.start_m = (req_r.start_minute > FULL_DAY) ? FULL_DAY
                                                                  : req_r.start_minute;
                wr_data.end_m = (req_r.end_minute > FULL_DAY) ? FULL_DAY
                                                              : req_r.end_minute;
                wr_data.mask  = req_r.weekday_mask;
                wr_data.act   = req_r.activity_code;
                count_nxt     = count_r + 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (req_r.entry_id == '0) begin
                status_nxt = ST_ZERO_ID;
              end else if (!hit) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                // move the tail down one slot, idx_r already points past the hit
                state_nxt     = S_SHIFT;
                out_valid_nxt = 1'b0;
                pos_nxt       = idx_r - 1'b1;
              end
            end
            REQ_SKIP: begin
              if (req_r.entry_id == '0) begin
                status_nxt = ST_ZERO_ID;
              end else if (!hit) begin
                status_nxt = ST_NOT_FOUND;
              end else if (now_r != req_r.entry_id) begin
                prior_nxt   = now_r;
                now_nxt     = req_r.entry_id;
                ent_chg_nxt = 1'b1;
                cur_act_nxt = rd_data.act;
              end
            end
            REQ_ACTIVE: begin
              if (req_r.active_flag != enabled_r) begin
                enabled_nxt = req_r.active_flag;
                act_chg_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT: begin
        // write back the entry read last cycle one slot lower
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pos_r[IW-1:0];
          pos_nxt = pos_r + 1'b1;
        end
        if (idx_r < count_r) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt     = count_r - 1'b1;
            if (now_r == req_r.entry_id) begin
              now_nxt     = '0;
              cur_act_nxt = '0;
            end
            status_nxt    = ST_OK;
            ent_chg_nxt   = 1'b0;
            act_chg_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      pos_r       <= '0;
      count_r     <= '0;
      now_r       <= '0;
      prior_r     <= '0;
      cur_act_r   <= '0;
      enabled_r   <= 1'b1;
      status_r    <= ST_OK;
      ent_chg_r   <= 1'b0;
      act_chg_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      now_r       <= now_nxt;
      prior_r     <= prior_nxt;
      cur_act_r   <= cur_act_nxt;
      enabled_r   <= enabled_nxt;
      status_r    <= status_nxt;
      ent_chg_r   <= ent_chg_nxt;
      act_chg_r   <= act_chg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    wd_r     <= wd_nxt;
    has_wd_r <= has_wd_nxt;
  end

  // Ports
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = '{status:           status_r,
                       entry_changed:    ent_chg_r,
                       active_changed:   act_chg_r,
                       current_entry:    now_r,
                       previous_entry:   prior_r,
                       current_activity: cur_act_r,
                       schedule_enabled: enabled_r};

endmodule

>>> src/tws_table.sv
module tws_table #(
  parameter int SLOTS = tws_pkg::TABLE_SLOTS_DEF,
  parameter int IW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  tws_pkg::entry_t wr_data,
  input  logic [IW-1:0]   rd_addr,
  output tws_pkg::entry_t rd_data
);
  import tws_pkg::*;

  entry_t mem [SLOTS];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/tws_match.sv
module tws_match (
  input  tws_pkg::entry_t     ent,
  input  tws_pkg::match_key_t key,
  output tws_pkg::match_res_t res
);
  import tws_pkg::*;

  logic day_ok;
  logic in_win;

  // Weekday filter, then window test; start past end wraps midnight
  always_comb begin
    day_ok = (ent.mask == '0) || (key.has_wd && ent.mask[key.wd]);
    if (ent.start_m <= ent.end_m) begin
      in_win = (key.tod >= ent.start_m) && (key.tod < ent.end_m);
    end else begin
      in_win = (key.tod >= ent.start_m) || (key.tod < ent.end_m);
    end
    res.id_hit  = (ent.id == key.id);
    res.win_hit = day_ok && in_win;
  end

endmodule

>>> src/tws_checker.sv
module tws_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input tws_pkg::in_item_t  in_data,
  input logic               busy,
  input logic               out_valid,
  input tws_pkg::out_item_t out_data
);
  import tws_pkg::*;

  // A taken request always makes the block busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request beat taken but block not busy next cycle");

  // Result beats never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A reported change moves the current entry away from the previous one
  a_change_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.entry_changed) |->
      (out_data.current_entry != out_data.previous_entry))
    else $error("entry change reported with equal current and previous");

  // No current entry means no activity
  a_idle_activity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.current_entry == '0)) |->
      (out_data.current_activity == '0))
    else $error("activity reported with no current entry");

endmodule

bind time_window_schedule_matcher tws_checker u_tws_checker (.*);

>>> tb/sv/schedule_checker.sv
`timescale 1ns / 1ps
module schedule_checker #(
  parameter int SLOTS = tws_pkg::TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  tws_pkg::in_item_t   in_data,
  input  logic                out_valid,
  input  tws_pkg::out_item_t  out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  replies_checked,
  output int                  entry_switches
);
  import tws_pkg::*;

  localparam int WEEK_DAYS  = 7;
  localparam int SHOW_LIMIT = 10;

  // Shadow copy of the schedule table and the current-entry state
  entry_t          sched_tbl [SLOTS];
  int              tbl_count;
  logic [ID_W-1:0] cur_id;
  logic [ID_W-1:0] prev_id;
  logic            sched_on;

  out_item_t awaited_replies [$];
  out_item_t want;
  out_item_t next_reply;
  int        mismatches;
  int        switches;
  int        checked;

  // Slot index holding id, -1 when absent
  function automatic int find_entry(input logic [ID_W-1:0] id);
    int i;
    for (i = 0; i < tbl_count; i++) begin
      if (sched_tbl[i].id == id) return i;
    end
    return -1;
  endfunction

  function automatic logic [MIN_W-1:0] clamp_day(input logic [MIN_W-1:0] m);
    return (m > FULL_DAY) ? FULL_DAY : m;
  endfunction

  // Advance the shadow state by one request and form its reply
  task automatic predict_reply(input in_item_t rq, output out_item_t rs);
    int              i;
    int              pos;
    int              wd;
    logic            has_wd;
    logic            day_ok;
    logic            in_win;
    logic [ID_W-1:0] hit_id;
    entry_t          ent;
    rs        = '0;
    rs.status = ST_OK;
    case (rq.req_type)
      REQ_TICK: begin
        if (sched_on) begin
          has_wd = (rq.world_day != '0);
          wd     = has_wd ? (int'(rq.world_day) - 1) % WEEK_DAYS : 0;
          hit_id = '0;
          // first entry in table order that fits the weekday and window
          for (i = 0; i < tbl_count && hit_id == '0; i++) begin
            ent    = sched_tbl[i];
            day_ok = (ent.mask == '0) || (has_wd && ent.mask[wd]);
            if (ent.start_m <= ent.end_m)
              in_win = (rq.time_of_day >= ent.start_m) && (rq.time_of_day < ent.end_m);
            else
              in_win = (rq.time_of_day >= ent.start_m) || (rq.time_of_day < ent.end_m);
            if (day_ok && in_win) hit_id = ent.id;
          end
          if (hit_id != cur_id) begin
            prev_id          = cur_id;
            cur_id           = hit_id;
            rs.entry_changed = 1'b1;
          end
        end
      end
      REQ_ADD: begin
        if (rq.entry_id == '0) begin
          rs.status = ST_ZERO_ID;
        end else if (find_entry(rq.entry_id) >= 0) begin
          rs.status = ST_DUP;
        end else if (tbl_count >= SLOTS) begin
          rs.status = ST_FULL;
        end else begin
          ent.id               = rq.entry_id;
          ent.start_m          = clamp_day(rq.start_minute);
          ent.end_m            = clamp_day(rq.end_minute);
          ent.mask             = rq.weekday_mask;
          ent.act              = rq.activity_code;
          sched_tbl[tbl_count] = ent;
          tbl_count++;
        end
      end
      REQ_REMOVE: begin
        pos = find_entry(rq.entry_id);
        if (rq.entry_id == '0) begin
          rs.status = ST_ZERO_ID;
        end else if (pos < 0) begin
          rs.status = ST_NOT_FOUND;
        end else begin
          // close the gap, keep order
          for (i = pos; i + 1 < tbl_count; i++) sched_tbl[i] = sched_tbl[i + 1];
          tbl_count--;
          if (cur_id == rq.entry_id) cur_id = '0;
        end
      end
      REQ_SKIP: begin
        if (rq.entry_id == '0) begin
          rs.status = ST_ZERO_ID;
        end else if (find_entry(rq.entry_id) < 0) begin
          rs.status = ST_NOT_FOUND;
        end else if (cur_id != rq.entry_id) begin
          prev_id          = cur_id;
          cur_id           = rq.entry_id;
          rs.entry_changed = 1'b1;
        end
      end
      REQ_ACTIVE: begin
        if (rq.active_flag != sched_on) begin
          sched_on          = rq.active_flag;
          rs.active_changed = 1'b1;
        end
      end
      default: ;
    endcase
    if (cur_id != '0) begin
      pos = find_entry(cur_id);
      if (pos >= 0) rs.current_activity = sched_tbl[pos].act;
    end
    rs.current_entry    = cur_id;
    rs.previous_entry   = prev_id;
    rs.schedule_enabled = sched_on;
  endtask

  // Compare reply beats against predictions, then take in request beats
  always @(posedge clk) begin
    if (!rst_n) begin
      tbl_count = 0;
      cur_id    = '0;
      prev_id   = '0;
      sched_on  = 1'b1;
      awaited_replies.delete();
    end else begin
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: reply beat with no request waiting (status %0d, current %0d)",
                     $realtime, out_data.status, out_data.current_entry);
        end else begin
          want = awaited_replies.pop_front();
          checked++;
          if (want.entry_changed) switches++;
          if (out_data.status !== want.status ||
              out_data.entry_changed !== want.entry_changed ||
              out_data.active_changed !== want.active_changed ||
              out_data.current_entry !== want.current_entry ||
              out_data.previous_entry !== want.previous_entry ||
              out_data.current_activity !== want.current_activity ||
              out_data.schedule_enabled !== want.schedule_enabled) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
              $display("%0t: reply mismatch (expected/actual) status %0d/%0d entry_chg %0b/%0b",
                       $realtime, want.status, out_data.status,
                       want.entry_changed, out_data.entry_changed);
              $display("  active_chg %0b/%0b current %0d/%0d previous %0d/%0d",
                       want.active_changed, out_data.active_changed,
                       want.current_entry, out_data.current_entry,
                       want.previous_entry, out_data.previous_entry);
              $display("  activity %0d/%0d enabled %0b/%0b",
                       want.current_activity, out_data.current_activity,
                       want.schedule_enabled, out_data.schedule_enabled);
            end
          end
        end
      end
      if (start && !busy) begin
        predict_reply(in_data, next_reply);
        awaited_replies.push_back(next_reply);
      end
    end
    fail_count      <= mismatches;
    pending         <= awaited_replies.size();
    replies_checked <= checked;
    entry_switches  <= switches;
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tws_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  localparam int RANDOM_REQS  = 500;
  localparam int POOL_IDS     = 20;
  localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS_DEF + 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       out_valid;
  in_item_t   in_data;
  out_item_t  out_data;

  int fail_count;
  int pending;
  int replies_checked;
  int entry_switches;
  int cycle_count = 0;
  int burst_left  = 0;
  int sent_by_code [8];

  time_window_schedule_matcher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  schedule_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .replies_checked (replies_checked),
    .entry_switches  (entry_switches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Every field but the request code random; request builders overwrite what matters
  function automatic in_item_t noise_item();
    in_item_t it;
    it.req_type      = REQ_TICK;
    it.entry_id      = ID_W'($urandom);
    it.start_minute  = MIN_W'($urandom);
    it.end_minute    = MIN_W'($urandom);
    it.weekday_mask  = MASK_W'($urandom);
    it.activity_code = ACT_W'($urandom);
    it.time_of_day   = MIN_W'($urandom);
    it.world_day     = DAY_W'($urandom);
    it.active_flag   = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t tick_req(input logic [MIN_W-1:0] tod,
                                        input logic [DAY_W-1:0] day);
    in_item_t it;
    it             = noise_item();
    it.time_of_day = tod;
    it.world_day   = day;
    return it;
  endfunction

  function automatic in_item_t add_req(input logic [ID_W-1:0] id,
                                       input logic [MIN_W-1:0] s,
                                       input logic [MIN_W-1:0] e,
                                       input logic [MASK_W-1:0] m,
                                       input logic [ACT_W-1:0] a);
    in_item_t it;
    it               = noise_item();
    it.req_type      = REQ_ADD;
    it.entry_id      = id;
    it.start_minute  = s;
    it.end_minute    = e;
    it.weekday_mask  = m;
    it.activity_code = a;
    return it;
  endfunction

  function automatic in_item_t id_req(input logic [REQ_W-1:0] code,
                                      input logic [ID_W-1:0] id);
    in_item_t it;
    it          = noise_item();
    it.req_type = code;
    it.entry_id = id;
    return it;
  endfunction

  function automatic in_item_t active_req(input logic flag);
    in_item_t it;
    it             = noise_item();
    it.req_type    = REQ_ACTIVE;
    it.active_flag = flag;
    return it;
  endfunction

  // Mostly a small pool so hits, duplicates and a full table happen
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 31);
    if (r == 0) return '0;
    if (r < 3) return ID_W'($urandom);
    return ID_W'($urandom_range(1, POOL_IDS));
  endfunction

  function automatic logic [MIN_W-1:0] pick_minute();
    if ($urandom_range(0, 9) == 0) return MIN_W'($urandom_range(FULL_DAY + 1, 2047));
    return MIN_W'($urandom_range(0, FULL_DAY));
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    if ($urandom_range(0, 3) == 0) return '0;
    return MASK_W'($urandom_range(1, 127));
  endfunction

  function automatic logic [MIN_W-1:0] pick_tod();
    if ($urandom_range(0, 15) == 0) return MIN_W'($urandom_range(FULL_DAY, 2047));
    return MIN_W'($urandom_range(0, FULL_DAY - 1));
  endfunction

  function automatic logic [DAY_W-1:0] pick_day();
    if ($urandom_range(0, 15) == 0) return '0;
    return DAY_W'($urandom_range(1, 65535));
  endfunction

  // Present one request beat, wait for acceptance, then maybe pause
  task automatic issue(input in_item_t it);
    int gap;
    in_data <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_by_code[it.req_type]++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    in_item_t it;
    int       n;
    int       pick;
    int       spare;
    logic     filling;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    filling = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, id zero, wrap window, clamping, weekday rules
    issue(tick_req(11'd600, 16'd1));
    issue(add_req('0, 11'd0, 11'd100, '0, 16'd5));
    issue(id_req(REQ_REMOVE, '0));
    issue(id_req(REQ_SKIP, '0));
    issue(add_req(16'd2, 11'd1380, 11'd60, 7'b0000001, 16'h1234));
    issue(add_req(16'd1, 11'd0, FULL_DAY, '0, 16'hFFFF));
    issue(add_req(16'd1, 11'd10, 11'd20, 7'h7F, 16'd0));
    issue(add_req(16'hFFFF, 11'd2047, 11'd2047, 7'h7F, 16'd0));
    issue(tick_req(11'd1400, 16'd1));
    issue(tick_req(11'd600, 16'd1));
    issue(tick_req(11'd30, 16'd0));
    issue(tick_req(11'd2000, 16'd8));
    // Skip hit and miss, remove miss
    issue(id_req(REQ_SKIP, 16'hFFFF));
    issue(id_req(REQ_SKIP, 16'hFFFF));
    issue(id_req(REQ_SKIP, 16'd777));
    issue(id_req(REQ_REMOVE, 16'd777));
    // Disabled schedule: ticks frozen, skip and remove still work
    issue(active_req(1'b0));
    issue(active_req(1'b0));
    issue(tick_req(11'd1400, 16'd1));
    issue(id_req(REQ_SKIP, 16'd1));
    issue(id_req(REQ_REMOVE, 16'd1));
    issue(active_req(1'b1));
    it          = noise_item();
    it.req_type = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    issue(it);
    // Match then lose the match
    issue(tick_req(11'd1400, 16'd1));
    issue(tick_req(11'd600, 16'd1));

    // Random: phases that fill the table alternate with phases that drain it
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % 50 == 0) filling = ~filling;
      pick = $urandom_range(0, 99);
      if (pick < 35)
        issue(tick_req(pick_tod(), pick_day()));
      else if (pick < (filling ? 70 : 45))
        issue(add_req(pick_id(), pick_minute(), pick_minute(), pick_mask(),
                      ACT_W'($urandom)));
      else if (pick < 80)
        issue(id_req(REQ_REMOVE, pick_id()));
      else if (pick < 88)
        issue(id_req(REQ_SKIP, pick_id()));
      else if (pick < 97)
        issue(active_req($urandom_range(0, 3) != 0));
      else begin
        it          = noise_item();
        it.req_type = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        issue(it);
      end
    end
    start <= 1'b0;

    // Drain, then let any stray beat show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    spare = 0;
    for (int c = REQ_SPARE_LO; c <= REQ_SPARE_HI; c++) spare += sent_by_code[c];
    $display("Requests sent: tick %0d, add %0d, remove %0d, skip %0d, set active %0d, spare %0d",
             sent_by_code[REQ_TICK], sent_by_code[REQ_ADD], sent_by_code[REQ_REMOVE],
             sent_by_code[REQ_SKIP], sent_by_code[REQ_ACTIVE], spare);
    $display("Replies checked: %0d, current entry changes: %0d, mismatches: %0d",
             replies_checked, entry_switches, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
